// ===== hdl/bcrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bcrf_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int ROW_W       = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_FLUSH = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic grid_we;     // store the accepted row
		logic rd_en;       // read grid and reached at rd_addr
		logic emit;        // this read feeds the output register
		logic last;        // this emit read is the final row
		logic first;       // first sweep: seed from grid instead of reached
		logic sweep_start; // clear the change flag
		logic flush;       // process the last row with no row below
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic rd_pend;  // read data arrives this cycle
		logic changed;  // some row changed in this sweep
		logic out_free; // output register can take a word next cycle
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/bcrf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bcrf_datapath #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64,
	parameter int AW          = 6,
	parameter int CLW         = 7
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  bcrf_pkg::cmd_t           cmd,
	output bcrf_pkg::sts_t           sts,
	input  wire [AW-1:0]             wr_addr,
	input  wire [AW-1:0]             rd_addr,
	input  wire [AW-1:0]             last_addr,
	input  wire [CLW-1:0]            cols_eff,
	input  wire [bcrf_pkg::ROW_W-1:0] row_in,
	input  wire                      result_stall,
	output logic                     result_valid,
	output logic [bcrf_pkg::ROW_W-1:0] result_bits,
	output logic                     result_last
);
	import bcrf_pkg::*;

	logic [MAX_COLUMNS-1:0] grid_mem  [MAX_ROWS];
	logic [MAX_COLUMNS-1:0] reach_mem [MAX_ROWS];

	logic [MAX_COLUMNS-1:0] grid_rd_s1, reach_rd_s1;
	logic                   rd_valid_s1, emit_s1, last_s1, first_s1;
	logic [AW-1:0]          addr_s1;

	logic [MAX_COLUMNS-1:0] prev_q, cur_q, gcur_q;
	logic [AW-1:0]          cur_addr_q;
	logic                   changed_q;

	logic                   out_valid_q, out_last_q;
	logic [MAX_COLUMNS-1:0] out_bits_q;

	logic [MAX_COLUMNS-1:0] cm, edge_m, arr_g, arr_r, below, nxt;
	logic                   arrive, proc;

	always_comb begin
		for (int j = 0; j < MAX_COLUMNS; j++) begin
			cm[j]     = (j < int'(cols_eff));
			edge_m[j] = (j == 0) || (j == int'(cols_eff) - 1);
		end
	end

	assign arrive = rd_valid_s1 && !emit_s1;
	assign arr_g  = grid_rd_s1 & cm;
	assign arr_r  = first_s1 ?
		(((addr_s1 == '0) || (addr_s1 == last_addr)) ? arr_g : (arr_g & edge_m)) :
		(reach_rd_s1 & cm);
	assign proc   = (arrive && (addr_s1 != '0)) || cmd.flush;
	assign below  = cmd.flush ? '0 : arr_r;
	assign nxt    = (cur_q | (cur_q << 1) | (cur_q >> 1) | prev_q | below) & gcur_q;

	// Memories and payload registers.
	always_ff @(posedge clk) begin
		if (cmd.grid_we)
			grid_mem[wr_addr] <= row_in[MAX_COLUMNS-1:0] & cm;
		if (proc)
			reach_mem[cur_addr_q] <= nxt;
		if (cmd.rd_en) begin
			grid_rd_s1  <= grid_mem[rd_addr];
			reach_rd_s1 <= reach_mem[rd_addr];
			addr_s1     <= rd_addr;
			emit_s1     <= cmd.emit;
			last_s1     <= cmd.last;
			first_s1    <= cmd.first;
		end
		if (arrive) begin
			prev_q     <= (addr_s1 == '0) ? '0 : nxt;
			cur_q      <= arr_r;
			gcur_q     <= arr_g;
			cur_addr_q <= addr_s1;
		end
		if (rd_valid_s1 && emit_s1) begin
			out_bits_q <= reach_rd_s1;
			out_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.sweep_start)
				changed_q <= 1'b0;
			else if (proc && (nxt != cur_q))
				changed_q <= 1'b1;
			if (rd_valid_s1 && emit_s1)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.rd_pend  = rd_valid_s1;
	assign sts.changed  = changed_q;
	assign sts.out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result_bits  = ROW_W'(out_bits_q);
	assign result_last  = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/bcrf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bcrf_ctrl #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64,
	parameter int AW          = 6,
	parameter int CW          = 7,
	parameter int CLW         = 7
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             row_valid,
	output logic                            row_stall,
	input  wire                             cfg_valid,
	input  wire [bcrf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [bcrf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bcrf_pkg::cmd_t                  cmd,
	input  bcrf_pkg::sts_t                  sts,
	output logic [AW-1:0]                   wr_addr,
	output logic [AW-1:0]                   rd_addr,
	output logic [AW-1:0]                   last_addr,
	output logic [CLW-1:0]                  cols_eff
);
	import bcrf_pkg::*;

	state_t                state_q;
	logic [CFG_DATA_W-1:0] row_count_q, column_count_q;
	logic [CW-1:0]         rows_loaded_q, rows_eff, loaded_nxt;
	logic [AW-1:0]         ptr_q;
	logic                  first_q;
	int unsigned           rc, cc, rw, cw;

	always_comb begin
		rc = row_count_q;
		cc = column_count_q;
		rw = (rc == 0) ? 1 : ((rc > MAX_ROWS) ? MAX_ROWS : rc);
		cw = (cc == 0) ? 1 : ((cc > MAX_COLUMNS) ? MAX_COLUMNS : cc);
		rows_eff  = CW'(rw);
		cols_eff  = CLW'(cw);
		last_addr = AW'(rw - 1);
	end

	assign row_stall  = (state_q != ST_LOAD);
	assign loaded_nxt = rows_loaded_q + 1'b1;
	assign wr_addr    = rows_loaded_q[AW-1:0];
	assign rd_addr    = ptr_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LOAD:  cmd.grid_we = row_valid;
			ST_SWEEP: begin
				cmd.rd_en       = 1'b1;
				cmd.first       = first_q;
				cmd.sweep_start = (ptr_q == '0);
			end
			ST_FLUSH: cmd.flush = !sts.rd_pend;
			ST_CHECK: ;
			ST_EMIT: begin
				cmd.rd_en = sts.out_free && !sts.rd_pend;
				cmd.emit  = 1'b1;
				cmd.last  = (ptr_q == last_addr);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			row_count_q    <= CFG_DATA_W'(64);
			column_count_q <= CFG_DATA_W'(64);
			rows_loaded_q  <= '0;
			ptr_q          <= '0;
			first_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ROW_COUNT:    row_count_q    <= cfg_data;
					CFG_COLUMN_COUNT: column_count_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_LOAD: begin
					if (row_valid) begin
						if (loaded_nxt >= rows_eff) begin
							rows_loaded_q <= '0;
							ptr_q         <= '0;
							first_q       <= 1'b1;
							state_q       <= ST_SWEEP;
						end else begin
							rows_loaded_q <= loaded_nxt;
						end
					end
				end
				ST_SWEEP: begin
					if (ptr_q == last_addr)
						state_q <= ST_FLUSH;
					else
						ptr_q <= ptr_q + 1'b1;
				end
				ST_FLUSH: begin
					if (!sts.rd_pend)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					ptr_q   <= '0;
					first_q <= 1'b0;
					state_q <= (sts.changed || first_q) ? ST_SWEEP : ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.rd_en) begin
						if (cmd.last)
							state_q <= ST_LOAD;
						else
							ptr_q <= ptr_q + 1'b1;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/border_connected_region_fill_unit.sv =====
// Border-connected region fill. Rows of a binary grid (bit j set = cell j open) enter one
// word per cycle on row_open_bits until row_count rows are stored. The unit then keeps
// only open cells that reach the grid border through 4-adjacent open cells and returns
// the grid one word per row on result_row_bits, with last_row set on the final word.
// Columns at or above column_count read back as zero. Per grid: the rows are loaded, then
// repeated sweeps run (one row per cycle through the single read port of the grid and
// reached-mask memories) until a sweep changes nothing, at least two sweeps, then the rows
// are emitted, each emit read waiting for the previous read's data and a free output
// register. Configuration is written through cfg_valid/cfg_index/cfg_data (index 0
// row_count, 1 column_count); cfg_ready is always high, and writes belong between grids.
`timescale 1ns / 1ps
`default_nettype none
module border_connected_region_fill_unit #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             row_valid,
	output logic                            row_stall,
	input  wire [bcrf_pkg::ROW_W-1:0]       row_open_bits,
	output logic                            result_valid,
	input  wire                             result_stall,
	output logic [bcrf_pkg::ROW_W-1:0]      result_row_bits,
	output logic                            last_row,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [bcrf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [bcrf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bcrf_pkg::*;

	// Address covers the grid depth; counters also hold the depth itself.
	localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = $clog2(MAX_ROWS + 1);
	localparam int CLW = $clog2(MAX_COLUMNS + 1);

	cmd_t           cmd;
	sts_t           sts;
	logic [AW-1:0]  wr_addr, rd_addr, last_addr;
	logic [CLW-1:0] cols_eff;

	// Registers are always writable.
	assign cfg_ready = 1'b1;

	// Sequencer: load, sweep, flush, check for convergence, emit.
	bcrf_ctrl #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .AW(AW), .CW(CW), .CLW(CLW)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.row_valid(row_valid), .row_stall(row_stall),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts),
		.wr_addr(wr_addr), .rd_addr(rd_addr), .last_addr(last_addr), .cols_eff(cols_eff)
	);

	// Grid and reached-mask memories, sweep window, output register.
	bcrf_datapath #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .AW(AW), .CLW(CLW)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.wr_addr(wr_addr), .rd_addr(rd_addr), .last_addr(last_addr), .cols_eff(cols_eff),
		.row_in(row_open_bits),
		.result_stall(result_stall), .result_valid(result_valid),
		.result_bits(result_row_bits), .result_last(last_row)
	);

	// A row is stored only on an accepted word.
	a_store_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grid_we |-> (row_valid && !row_stall))
		else $error("grid write without accepted word");

	// An emit read may only start when the output register frees up next cycle.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.emit) |-> (!result_valid || !result_stall))
		else $error("emit read would overwrite a waiting word");

	// The last row is processed only after its read data has arrived.
	a_flush_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> !sts.rd_pend)
		else $error("flush while a read is in flight");

endmodule
`default_nettype wire
